// ===== src/kbs_pkg.sv =====
// ----------------------------------------------------------------------------
// kbs_pkg
// Shared types, constants and helpers for the keyed byte shuffle core.
// ----------------------------------------------------------------------------
package kbs_pkg;

    // Block geometry
    localparam int BLOCK_BYTES = 16;
    localparam int IDX_W       = 4;
    localparam int WORD_W      = 64;
    localparam int BLOCK_W     = 2 * WORD_W;

    // Operation codes
    localparam logic OP_FORWARD = 1'b0;
    localparam logic OP_INVERSE = 1'b1;

    // Hex character bounds
    localparam logic [7:0] CHR_0      = 8'h30;
    localparam logic [7:0] CHR_9      = 8'h39;
    localparam logic [7:0] CHR_LA     = 8'h61;
    localparam logic [7:0] CHR_LF     = 8'h66;
    localparam logic [7:0] CHR_UA     = 8'h41;
    localparam logic [7:0] CHR_UF     = 8'h46;
    localparam logic [7:0] DIGIT_TEN  = 8'd10;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;   // capture a new block and key, reset the pattern
        logic step;   // perform one swap and rotate the pattern
        logic apply;  // permute the block into the result register
    } t_ctrl_cmd;

    // Decode one key byte as a hex digit; anything else reads as zero
    function automatic logic [IDX_W-1:0] hex_digit(input logic [7:0] c);
        logic [7:0] d;
        d = 8'h00;
        if (c >= CHR_0 && c <= CHR_9) begin
            d = c - CHR_0;
        end else if (c >= CHR_LA && c <= CHR_LF) begin
            d = c - CHR_LA + DIGIT_TEN;
        end else if (c >= CHR_UA && c <= CHR_UF) begin
            d = c - CHR_UA + DIGIT_TEN;
        end
        return d[IDX_W-1:0];
    endfunction

endpackage

// ===== src/kbs_if.sv =====
// ----------------------------------------------------------------------------
// kbs_if
// Valid/ready channel interfaces for the keyed byte shuffle core.
// ----------------------------------------------------------------------------

// Input channel: one block, key and direction per beat
interface kbs_in_if
    import kbs_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              operation;
    logic [WORD_W-1:0] data_low;
    logic [WORD_W-1:0] data_high;
    logic [WORD_W-1:0] key_low;
    logic [WORD_W-1:0] key_high;

    modport source (
        output valid, operation, data_low, data_high, key_low, key_high,
        input  ready
    );
    modport sink (
        input  valid, operation, data_low, data_high, key_low, key_high,
        output ready
    );
endinterface

// Output channel: one permuted block per beat
interface kbs_out_if
    import kbs_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] result_low;
    logic [WORD_W-1:0] result_high;

    modport source (
        output valid, result_low, result_high,
        input  ready
    );
    modport sink (
        input  valid, result_low, result_high,
        output ready
    );
endinterface

// ===== src/kbs_ctrl.sv =====
// ----------------------------------------------------------------------------
// kbs_ctrl
// Sequencer: accepts a beat, runs sixteen swap steps, then applies the
// permutation into the output register when that register is free.
// ----------------------------------------------------------------------------
module kbs_ctrl
    import kbs_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_ctrl_cmd o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SWAP,
        S_APPLY
    } t_state;

    t_state           r_state, n_state;
    logic [IDX_W-1:0] r_count, n_count;
    logic             r_out_valid, n_out_valid;
    logic             out_free;

    // Output register can take a new beat when empty or draining now
    assign out_free = !r_out_valid || i_out_ready;

    // Issue commands
    always_comb begin
        o_in_ready  = (r_state == S_IDLE) || ((r_state == S_APPLY) && out_free);
        o_cmd.load  = i_in_valid && o_in_ready;
        o_cmd.step  = (r_state == S_SWAP);
        o_cmd.apply = (r_state == S_APPLY) && out_free;
    end

    // Compute next state
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_out_valid = r_out_valid;

        if (o_cmd.apply) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (o_cmd.load) begin
                    n_state = S_SWAP;
                    n_count = '0;
                end
            end
            S_SWAP: begin
                n_count = r_count + 1'b1;
                if (r_count == IDX_W'(BLOCK_BYTES - 1)) begin
                    n_state = S_APPLY;
                end
            end
            S_APPLY: begin
                if (out_free) begin
                    n_count = '0;
                    n_state = o_cmd.load ? S_SWAP : S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Hold state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

// ===== src/kbs_dp.sv =====
// ----------------------------------------------------------------------------
// kbs_dp
// Datapath: pattern register with one swap unit, key digit ring, block
// register and the byte crossbar feeding the result register.
// ----------------------------------------------------------------------------
module kbs_dp
    import kbs_pkg::*;
(
    input  logic              i_clk,
    input  t_ctrl_cmd         i_cmd,
    input  logic              i_operation,
    input  logic [WORD_W-1:0] i_data_low,
    input  logic [WORD_W-1:0] i_data_high,
    input  logic [WORD_W-1:0] i_key_low,
    input  logic [WORD_W-1:0] i_key_high,
    output logic [WORD_W-1:0] o_result_low,
    output logic [WORD_W-1:0] o_result_high
);

    logic [IDX_W-1:0] r_pat   [BLOCK_BYTES];
    logic [IDX_W-1:0] n_pat   [BLOCK_BYTES];
    logic [IDX_W-1:0] r_dig   [BLOCK_BYTES];
    logic [7:0]       r_byte  [BLOCK_BYTES];
    logic             r_op;
    logic [BLOCK_W-1:0] r_res;
    logic [BLOCK_W-1:0] perm;
    logic [BLOCK_W-1:0] in_data;
    logic [BLOCK_W-1:0] in_key;
    logic [IDX_W-1:0] pick;
    logic [IDX_W-1:0] sw    [BLOCK_BYTES];

    assign in_data = {i_data_high, i_data_low};
    assign in_key  = {i_key_high, i_key_low};

    // Swap the head entry with the entry that the head key digit points at, then rotate left
    // so the next entry to process sits at the head
    always_comb begin
        pick = '0;
        for (int k = 0; k < BLOCK_BYTES; k++) begin
            if (r_dig[0] == IDX_W'(k)) begin
                pick = pick | r_pat[k];
            end
        end
        for (int k = 0; k < BLOCK_BYTES; k++) begin
            if (k == 0) begin
                sw[k] = pick;
            end else if (r_dig[0] == IDX_W'(k)) begin
                sw[k] = r_pat[0];
            end else begin
                sw[k] = r_pat[k];
            end
        end
        for (int k = 0; k < BLOCK_BYTES; k++) begin
            n_pat[k] = sw[(k + 1) % BLOCK_BYTES];
        end
    end

    // Route bytes through the pattern
    always_comb begin
        perm = '0;
        for (int p = 0; p < BLOCK_BYTES; p++) begin
            for (int i = 0; i < BLOCK_BYTES; i++) begin
                if ((r_op == OP_INVERSE) ? (r_pat[p] == IDX_W'(i))
                                         : (r_pat[i] == IDX_W'(p))) begin
                    perm[8*p +: 8] = perm[8*p +: 8] | r_byte[i];
                end
            end
        end
    end

    // Load, step and rotate working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op <= i_operation;
            for (int k = 0; k < BLOCK_BYTES; k++) begin
                r_pat[k]  <= IDX_W'(k);
                r_dig[k]  <= hex_digit(in_key[8*k +: 8]);
                r_byte[k] <= in_data[8*k +: 8];
            end
        end else if (i_cmd.step) begin
            for (int k = 0; k < BLOCK_BYTES; k++) begin
                r_pat[k] <= n_pat[k];
                r_dig[k] <= r_dig[(k + 1) % BLOCK_BYTES];
            end
        end
    end

    // Capture the permuted block
    always_ff @(posedge i_clk) begin
        if (i_cmd.apply) begin
            r_res <= perm;
        end
    end

    assign o_result_low  = r_res[WORD_W-1:0];
    assign o_result_high = r_res[BLOCK_W-1:WORD_W];

endmodule

// ===== src/keyed_byte_shuffle_core.sv =====
// ----------------------------------------------------------------------------
// keyed_byte_shuffle_core
// Keyed byte permutation of a 16-byte block, forward or inverse.
//
//   Channel | Dir | Payload                                         | Handshake
//   i_in    | in  | operation, data_low/high, key_low/high          | valid/ready
//   o_out   | out | result_low/high                                 | valid/ready
//
// Sixteen swap steps through the single swap unit build the pattern, then the
// apply step routes the bytes into the output register. A new beat is taken in
// the apply cycle, while the previous block's result is captured.
// Synchronous active-low reset clears the sequencer and the output valid.
// A stalled output only holds the apply cycle until the result drains.
// ----------------------------------------------------------------------------
module keyed_byte_shuffle_core
    import kbs_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    kbs_in_if.sink    i_in,
    kbs_out_if.source o_out
);

    t_ctrl_cmd cmd;

    // Sequencer
    kbs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_cmd       (cmd)
    );

    // Datapath
    kbs_dp u_dp (
        .i_clk         (i_clk),
        .i_cmd         (cmd),
        .i_operation   (i_in.operation),
        .i_data_low    (i_in.data_low),
        .i_data_high   (i_in.data_high),
        .i_key_low     (i_in.key_low),
        .i_key_high    (i_in.key_high),
        .o_result_low  (o_out.result_low),
        .o_result_high (o_out.result_high)
    );

    // Check sequencing
    a_load_then_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load |=> cmd.step)
        else $error("swap steps did not start after a beat was taken");

    a_apply_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.apply |=> !cmd.apply)
        else $error("apply issued on two consecutive cycles");

    a_no_back_to_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !(i_in.valid && i_in.ready))
        else $error("beat taken while a block is still being shuffled");

endmodule
